>>> hw/rtl/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg: shared types and constants for the DRAM address mapper
// Field widths, register indexes, reset values and small mask helpers.
// ----------------------------------------------------------------------------
package dam_pkg;

    localparam int ADDR_WIDTH     = 48;
    localparam int LOW_COL_BITS   = 2;
    localparam int LEVEL_MAX_BITS = 8;
    localparam int COL_MAX_BITS   = 16;
    localparam int LEVEL_WIDTH    = 8;
    localparam int ROW_WIDTH      = 31;
    localparam int COL_WIDTH      = 16;
    localparam int COL_HI_WIDTH   = COL_WIDTH - LOW_COL_BITS;

    localparam int OFFSET_W = 4;
    localparam int LVLW_W   = 4;
    localparam int ROWW_W   = 5;
    localparam int COLW_W   = 5;
    localparam int POS_W    = 5;
    localparam int SHAMT_W  = 7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OFFSET_BITS = 3'd0,
        CFG_LEVEL0_BITS = 3'd1,
        CFG_LEVEL1_BITS = 3'd2,
        CFG_LEVEL2_BITS = 3'd3,
        CFG_ROW_BITS    = 3'd4,
        CFG_COLUMN_BITS = 3'd5
    } t_cfg_index;

    localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS = 4'd6;
    localparam logic [LVLW_W-1:0]   RST_LEVEL0_BITS = 4'd1;
    localparam logic [LVLW_W-1:0]   RST_LEVEL1_BITS = 4'd2;
    localparam logic [LVLW_W-1:0]   RST_LEVEL2_BITS = 4'd2;
    localparam logic [ROWW_W-1:0]   RST_ROW_BITS    = 5'd16;
    localparam logic [COLW_W-1:0]   RST_COLUMN_BITS = 5'd10;

    // Saturate a level width at eight bits.
    function automatic logic [LVLW_W-1:0] sat_level(input logic [LVLW_W-1:0] w);
        if (w > LVLW_W'(LEVEL_MAX_BITS)) begin
            return LVLW_W'(LEVEL_MAX_BITS);
        end
        return w;
    endfunction

    // Clamp the column width into two..sixteen.
    function automatic logic [COLW_W-1:0] clamp_col(input logic [COLW_W-1:0] w);
        if (w < COLW_W'(LOW_COL_BITS)) begin
            return COLW_W'(LOW_COL_BITS);
        end
        if (w > COLW_W'(COL_MAX_BITS)) begin
            return COLW_W'(COL_MAX_BITS);
        end
        return w;
    endfunction

    function automatic logic [LEVEL_WIDTH-1:0] mask_level(input logic [LVLW_W-1:0] w);
        return ~({LEVEL_WIDTH{1'b1}} << w);
    endfunction

    function automatic logic [ROW_WIDTH-1:0] mask_row(input logic [ROWW_W-1:0] w);
        return ~({ROW_WIDTH{1'b1}} << w);
    endfunction

    function automatic logic [COL_HI_WIDTH-1:0] mask_col_hi(input logic [COLW_W-1:0] w);
        return ~({COL_HI_WIDTH{1'b1}} << w);
    endfunction

endpackage

>>> hw/rtl/dram_address_mapper_xor.sv
// ----------------------------------------------------------------------------
// dram_address_mapper_xor: intra-channel address to DRAM coordinates
// Maps one byte address per unstalled cycle to three level indices, a row,
// and a column; levels and row are XORed by consecutive chunks of the column.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word. The block takes one word
// per clock cycle while the output does not stall and passes it through the
// input register and then the result register, with the shift/mask/XOR
// mapping between them. A stall on the output backs up through both registers
// one stage at a time, so one more word is still taken into the free input
// register while a finished result waits. Field widths come from six
// configuration registers (offset, three level widths, row width, column
// width), written through the plain write port; the user must write them only
// while no word is in flight; the block does not enforce this. Level widths
// above eight act as eight and the column width is held within two..sixteen.
module dram_address_mapper_xor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [dam_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [dam_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dam_pkg::ADDR_WIDTH-1:0]   i_address,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dam_pkg::LEVEL_WIDTH-1:0]  o_level0_index,
    output logic [dam_pkg::LEVEL_WIDTH-1:0]  o_level1_index,
    output logic [dam_pkg::LEVEL_WIDTH-1:0]  o_level2_index,
    output logic [dam_pkg::ROW_WIDTH-1:0]    o_row_index,
    output logic [dam_pkg::COL_WIDTH-1:0]    o_column_index
);
    import dam_pkg::*;

    logic [OFFSET_W-1:0]    r_offset_bits;
    logic [LVLW_W-1:0]      r_level0_bits;
    logic [LVLW_W-1:0]      r_level1_bits;
    logic [LVLW_W-1:0]      r_level2_bits;
    logic [ROWW_W-1:0]      r_row_bits;
    logic [COLW_W-1:0]      r_column_bits;

    logic                   r_s1_valid;
    logic [ADDR_WIDTH-1:0]  r_s1_address;

    logic                   r_out_valid;
    logic [LEVEL_WIDTH-1:0] r_level0_index;
    logic [LEVEL_WIDTH-1:0] r_level1_index;
    logic [LEVEL_WIDTH-1:0] r_level2_index;
    logic [ROW_WIDTH-1:0]   r_row_index;
    logic [COL_WIDTH-1:0]   r_column_index;

    logic                   out_adv;
    logic                   in_take;

    logic [LVLW_W-1:0]      w0, w1, w2;
    logic [COLW_W-1:0]      colw, col_hi_w;
    logic [SHAMT_W-1:0]     sh_l0, sh_l1, sh_l2, sh_col, sh_row;
    logic [ADDR_WIDTH-1:0]  a_l0, a_l1, a_l2, a_col, a_row;
    logic [COL_HI_WIDTH-1:0] col_hi;
    logic [COL_WIDTH-1:0]   col;
    logic [POS_W-1:0]       pos1, pos2, pos3;
    logic [COL_WIDTH-1:0]   col_sh1, col_sh2, col_sh3;

    logic [LEVEL_WIDTH-1:0] n_level0_index;
    logic [LEVEL_WIDTH-1:0] n_level1_index;
    logic [LEVEL_WIDTH-1:0] n_level2_index;
    logic [ROW_WIDTH-1:0]   n_row_index;

    // Result register moves when empty or drained; input register follows it.
    assign out_adv = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || out_adv;
    assign in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= RST_OFFSET_BITS;
            r_level0_bits <= RST_LEVEL0_BITS;
            r_level1_bits <= RST_LEVEL1_BITS;
            r_level2_bits <= RST_LEVEL2_BITS;
            r_row_bits    <= RST_ROW_BITS;
            r_column_bits <= RST_COLUMN_BITS;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_LEVEL0_BITS: r_level0_bits <= i_cfg_wdata[LVLW_W-1:0];
                CFG_LEVEL1_BITS: r_level1_bits <= i_cfg_wdata[LVLW_W-1:0];
                CFG_LEVEL2_BITS: r_level2_bits <= i_cfg_wdata[LVLW_W-1:0];
                CFG_ROW_BITS:    r_row_bits    <= i_cfg_wdata[ROWW_W-1:0];
                CFG_COLUMN_BITS: r_column_bits <= i_cfg_wdata[COLW_W-1:0];
                default: ;
            endcase
        end
    end

    // Field boundaries: offset, two low column bits, three levels, column top.
    always_comb begin
        w0       = sat_level(r_level0_bits);
        w1       = sat_level(r_level1_bits);
        w2       = sat_level(r_level2_bits);
        colw     = clamp_col(r_column_bits);
        col_hi_w = colw - COLW_W'(LOW_COL_BITS);

        sh_l0  = SHAMT_W'(r_offset_bits) + SHAMT_W'(LOW_COL_BITS);
        sh_l1  = sh_l0 + SHAMT_W'(w0);
        sh_l2  = sh_l1 + SHAMT_W'(w1);
        sh_col = sh_l2 + SHAMT_W'(w2);
        sh_row = sh_col + SHAMT_W'(col_hi_w);

        a_l0  = r_s1_address >> sh_l0;
        a_l1  = r_s1_address >> sh_l1;
        a_l2  = r_s1_address >> sh_l2;
        a_col = r_s1_address >> sh_col;
        a_row = r_s1_address >> sh_row;

        col_hi = a_col[COL_HI_WIDTH-1:0] & mask_col_hi(col_hi_w);
        col    = {col_hi, a_l0[LOW_COL_BITS-1:0] ^ a_l0[LOW_COL_BITS-1:0]}
               | COL_WIDTH'((r_s1_address >> r_offset_bits) & ADDR_WIDTH'(3));

        // Chunks start where the previous level's chunk ended; zero widths add nothing.
        pos1    = POS_W'(w0);
        pos2    = pos1 + POS_W'(w1);
        pos3    = pos2 + POS_W'(w2);
        col_sh1 = col >> pos1;
        col_sh2 = col >> pos2;
        col_sh3 = col >> pos3;

        n_level0_index = (a_l0[LEVEL_WIDTH-1:0] ^ col[LEVEL_WIDTH-1:0]) & mask_level(w0);
        n_level1_index = (a_l1[LEVEL_WIDTH-1:0] ^ col_sh1[LEVEL_WIDTH-1:0])
                       & mask_level(w1);
        n_level2_index = (a_l2[LEVEL_WIDTH-1:0] ^ col_sh2[LEVEL_WIDTH-1:0])
                       & mask_level(w2);
        n_row_index    = a_row[ROW_WIDTH-1:0]
                       ^ (ROW_WIDTH'(col_sh3) & mask_row(r_row_bits));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_address <= i_address;
        end
        if (out_adv && r_s1_valid) begin
            r_level0_index <= n_level0_index;
            r_level1_index <= n_level1_index;
            r_level2_index <= n_level2_index;
            r_row_index    <= n_row_index;
            r_column_index <= col;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_level0_index = r_level0_index;
    assign o_level1_index = r_level1_index;
    assign o_level2_index = r_level2_index;
    assign o_row_index    = r_row_index;
    assign o_column_index = r_column_index;

endmodule

>>> hw/rtl/dam_checker.sv
// ----------------------------------------------------------------------------
// dam_checker: port-level checks for the DRAM address mapper
// Watches the handshakes on the top level and flags pipeline slips.
// ----------------------------------------------------------------------------
module dam_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [dam_pkg::LEVEL_WIDTH-1:0]  o_level0_index,
    input  logic [dam_pkg::LEVEL_WIDTH-1:0]  o_level1_index,
    input  logic [dam_pkg::LEVEL_WIDTH-1:0]  o_level2_index,
    input  logic [dam_pkg::ROW_WIDTH-1:0]    o_row_index,
    input  logic [dam_pkg::COL_WIDTH-1:0]    o_column_index
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // An empty result register always leaves room for a new word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // A taken word reaches the output if the result register can advance while it waits in the input register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 (!o_valid || i_ready) |=> o_valid)
        else $error("accepted word did not reach the output");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_level0_index)
            && $stable(o_level1_index) && $stable(o_level2_index)
            && $stable(o_row_index) && $stable(o_column_index)))
        else $error("stalled result changed");

endmodule

bind dram_address_mapper_xor dam_checker u_dam_checker (.*);
